// ===== sv/vt44_pkg.sv =====
// ----------------------------------------------------------------------------
// vt44_pkg: shared types and constants of the 4x4 vertex transform
// Word layouts, fixed-point format and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package vt44_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int CSR_W     = 64;
   localparam int NUM_REGS  = 8;
   localparam int IDX_W     = $clog2(NUM_REGS);
   localparam int PROD_W    = 2 * DATA_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   localparam int QUO_W     = DATA_W + FRAC_BITS;

   localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;

   localparam logic [IDX_W-1:0] REG_ROW0_COLS01 = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_ROW0_COLS23 = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_ROW1_COLS01 = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_ROW1_COLS23 = IDX_W'(3);
   localparam logic [IDX_W-1:0] REG_ROW2_COLS01 = IDX_W'(4);
   localparam logic [IDX_W-1:0] REG_ROW2_COLS23 = IDX_W'(5);
   localparam logic [IDX_W-1:0] REG_ROW3_COLS01 = IDX_W'(6);
   localparam logic [IDX_W-1:0] REG_ROW3_COLS23 = IDX_W'(7);

   typedef struct packed {
      logic               kind;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
      logic signed [31:0] in_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic               w_zero;
      logic               saturated;
   } rsp_type;

   // Side data that rides alongside the divider lanes
   typedef struct packed {
      logic                   do_div;
      logic                   w_zero;
      logic                   sat;
      logic [2:0]             neg;
      logic [3:0][DATA_W-1:0] res;
   } side_type;

   // Identity matrix in the current fixed-point format
   function automatic logic [CSR_W-1:0] coef_reset(input logic [IDX_W-1:0] idx);
      logic [CSR_W-1:0] val;
      case (idx)
         REG_ROW0_COLS01: val = {{DATA_W{1'b0}}, FIX_ONE};
         REG_ROW1_COLS01: val = {FIX_ONE, {DATA_W{1'b0}}};
         REG_ROW2_COLS23: val = {{DATA_W{1'b0}}, FIX_ONE};
         REG_ROW3_COLS23: val = {FIX_ONE, {DATA_W{1'b0}}};
         default:         val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== sv/vertex_transform_4x4.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_4x4: 4x4 matrix times homogeneous vertex, Q16.16
// Optional perspective divide with saturation and zero-w flag.
// ----------------------------------------------------------------------------
// One vertex word enters per cycle and one result word leaves per cycle
// while the pipe advances; vertex components are Q16.16. Stage 1 holds the
// sixteen 32x32 products, stage 2 the pairwise sums, stage 3 the floored,
// saturated dot products; then three divider lanes of 32 + FRAC_BITS stages
// (one quotient bit each) run for every word, and a final register applies
// signs and clamps. The whole pipe advances together whenever the output
// register is empty or being taken, and req_ready is high exactly then. Matrix
// registers take a write every cycle and should only change while no word
// is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_4x4
   import vt44_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]  csr_data
);

   // Matrix registers
   logic [CSR_W-1:0] coef_ff [NUM_REGS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= coef_reset(IDX_W'(i));
         end
      end else if (csr_valid && csr_ready) begin
         coef_ff[csr_index] <= csr_data;
      end
   end

   // Whole pipe moves when the output word is empty or being taken
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Stage 1: products
   logic signed [DATA_W-1:0] vec [4];
   logic signed [PROD_W-1:0] prod_ff [4][4];
   logic                     v1_ff, kind1_ff;

   assign vec[0] = req_payload.in_x;
   assign vec[1] = req_payload.in_y;
   assign vec[2] = req_payload.in_z;
   assign vec[3] = req_payload.in_w;

   genvar r, c;
   generate
      for (r = 0; r < 4; r++) begin : g_row
         for (c = 0; c < 4; c++) begin : g_col
            localparam int REG_SEL = r * 2 + c / 2;
            logic signed [DATA_W-1:0] coef;
            logic signed [PROD_W-1:0] prod_in;
            if (c % 2 == 1) begin : g_hi
               assign coef = coef_ff[REG_SEL][CSR_W-1:DATA_W];
            end else begin : g_lo
               assign coef = coef_ff[REG_SEL][DATA_W-1:0];
            end
            assign prod_in = PROD_W'(coef) * PROD_W'(vec[c]);
            always_ff @(posedge clock) begin
               if (advance) begin
                  prod_ff[r][c] <= prod_in;
               end
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind1_ff <= req_payload.kind;
      end
   end

   // Stage 2: pairwise sums
   logic signed [PAIR_W-1:0] pair_ff [4][2];
   logic                     v2_ff, kind2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind2_ff <= kind1_ff;
         for (int i = 0; i < 4; i++) begin
            pair_ff[i][0] <= PAIR_W'(prod_ff[i][0]) + PAIR_W'(prod_ff[i][1]);
            pair_ff[i][1] <= PAIR_W'(prod_ff[i][2]) + PAIR_W'(prod_ff[i][3]);
         end
      end
   end

   // Stage 3: full sum, floor shift, clamp to 32 bits
   logic signed [SUM_W-1:0]  sum_c [4];
   logic signed [SUM_W-1:0]  shr_c [4];
   logic signed [DATA_W-1:0] res_in [4];
   logic [3:0]               ovf_c;
   logic signed [DATA_W-1:0] res3_ff [4];
   logic                     v3_ff, kind3_ff, sat3_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sum_c[i] = SUM_W'(pair_ff[i][0]) + SUM_W'(pair_ff[i][1]);
         shr_c[i] = sum_c[i] >>> FRAC_BITS;
         ovf_c[i] = !((&shr_c[i][SUM_W-1:DATA_W-1]) || !(|shr_c[i][SUM_W-1:DATA_W-1]));
         if (ovf_c[i]) begin
            res_in[i] = shr_c[i][SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                          : {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            res_in[i] = shr_c[i][DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind3_ff <= kind2_ff;
         sat3_ff  <= |ovf_c;
         for (int i = 0; i < 4; i++) begin
            res3_ff[i] <= res_in[i];
         end
      end
   end

   // Divide: magnitudes into three lanes, signs and results alongside
   logic [DATA_W-1:0] mag [4];
   logic [QUO_W-1:0]  quo [3];
   side_type          side_in;
   side_type          side_ff [QUO_W];
   logic              vd_ff [QUO_W];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag[i] = res3_ff[i][DATA_W-1] ? DATA_W'(-res3_ff[i]) : res3_ff[i];
      end
      side_in.w_zero = kind3_ff && (res3_ff[3] == '0);
      side_in.do_div = kind3_ff && (res3_ff[3] != '0);
      side_in.sat    = sat3_ff;
      for (int i = 0; i < 3; i++) begin
         side_in.neg[i] = res3_ff[i][DATA_W-1] ^ res3_ff[3][DATA_W-1];
      end
      for (int i = 0; i < 4; i++) begin
         side_in.res[i] = res3_ff[i];
      end
   end

   genvar ln;
   generate
      for (ln = 0; ln < 3; ln++) begin : g_lane
         vt44_div_lane u_lane (
            .clock    (clock),
            .advance  (advance),
            .dividend ({mag[ln], {FRAC_BITS{1'b0}}}),
            .divisor  (mag[3]),
            .quotient (quo[ln])
         );
      end
   endgenerate

   // Side line runs in step with the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_W; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         vd_ff[0] <= v3_ff;
         for (int k = 1; k < QUO_W; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < QUO_W; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Output: apply sign, clamp quotients, pick result
   side_type          side_out;
   logic [DATA_W-1:0] qv [3];
   logic [2:0]        qsat;
   rsp_type           rsp_in;
   rsp_type           rsp_ff;

   assign side_out = side_ff[QUO_W-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (side_out.neg[i]) begin
            qsat[i] = (|quo[i][QUO_W-1:DATA_W])
                      || (quo[i][DATA_W-1] && (|quo[i][DATA_W-2:0]));
            qv[i]   = qsat[i] ? {1'b1, {(DATA_W-1){1'b0}}}
                              : DATA_W'(-quo[i][DATA_W-1:0]);
         end else begin
            qsat[i] = |quo[i][QUO_W-1:DATA_W-1];
            qv[i]   = qsat[i] ? {1'b0, {(DATA_W-1){1'b1}}} : quo[i][DATA_W-1:0];
         end
      end
      rsp_in.w_zero = side_out.w_zero;
      if (side_out.do_div) begin
         rsp_in.out_x     = qv[0];
         rsp_in.out_y     = qv[1];
         rsp_in.out_z     = qv[2];
         rsp_in.out_w     = FIX_ONE;
         rsp_in.saturated = side_out.sat || (|qsat);
      end else begin
         rsp_in.out_x     = side_out.res[0];
         rsp_in.out_y     = side_out.res[1];
         rsp_in.out_z     = side_out.res[2];
         rsp_in.out_w     = side_out.res[3];
         rsp_in.saturated = side_out.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vd_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // A zero-w word keeps the transformed w, which is zero
   a_wzero_w: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.w_zero |-> rsp_ff.out_w == '0)
      else $error("w_zero set with nonzero out_w");

   // Drop everything in flight on reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid_ff && !v1_ff && !v3_ff)
      else $error("pipe not empty after reset");

   // Hold the output word while the pipe is stalled
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(advance) |-> $stable(rsp_ff) && $stable(vd_ff[QUO_W-1]))
      else $error("output changed during stall");
`endif

endmodule

`default_nettype wire

// ===== sv/vt44_div_lane.sv =====
// ----------------------------------------------------------------------------
// vt44_div_lane: pipelined unsigned restoring divider
// One quotient bit per stage; a new division may enter every cycle that advance is high.
// ----------------------------------------------------------------------------
`default_nettype none

module vt44_div_lane
   import vt44_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              advance,
   input  wire logic [QUO_W-1:0]  dividend,
   input  wire logic [DATA_W-1:0] divisor,
   output logic      [QUO_W-1:0]  quotient
);

   logic [DATA_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0]  dq_ff  [QUO_W];
   logic [DATA_W-1:0] dvs_ff [QUO_W];

   genvar k;
   generate
      for (k = 0; k < QUO_W; k++) begin : g_stage
         logic [DATA_W-1:0] rem_src;
         logic [QUO_W-1:0]  dq_src;
         logic [DATA_W-1:0] dvs_src;
         logic [DATA_W:0]   shifted;
         logic [DATA_W:0]   trial;
         logic [DATA_W-1:0] rem_in;
         logic [QUO_W-1:0]  dq_in;

         if (k == 0) begin : g_first
            assign rem_src = '0;
            assign dq_src  = dividend;
            assign dvs_src = divisor;
         end else begin : g_next
            assign rem_src = rem_ff[k-1];
            assign dq_src  = dq_ff[k-1];
            assign dvs_src = dvs_ff[k-1];
         end

         always_comb begin
            shifted = {rem_src, dq_src[QUO_W-1]};
            trial   = shifted - {1'b0, dvs_src};
            if (!trial[DATA_W]) begin
               rem_in = trial[DATA_W-1:0];
               dq_in  = {dq_src[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[DATA_W-1:0];
               dq_in  = {dq_src[QUO_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k] <= rem_in;
               dq_ff[k]  <= dq_in;
               dvs_ff[k] <= dvs_src;
            end
         end
      end
   endgenerate

   assign quotient = dq_ff[QUO_W-1];

endmodule

`default_nettype wire

// ===== tb/sv/vertex_transform_4x4_tb.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_4x4_tb: self-checking bench for the 4x4 vertex transform
// Drives vertex words under bursty traffic and a stalling receiver, predicts
// each result in fixed point and compares results in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module vertex_transform_4x4_tb;
   import vt44_pkg::*;

   localparam int LATENCY     = 4 + DATA_W + FRAC_BITS;
   localparam int CYCLE_LIMIT = 400000;

   // Expected result queue plus mismatch bookkeeping
   class vertex_scoreboard;
      rsp_type pending[$];
      int      mismatches;

      function void note_vertex(input rsp_type exp_word);
         pending.push_back(exp_word);
      endfunction

      function void check_result(input rsp_type got);
         rsp_type exp_word;
         bit      bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word %h", got);
            return;
         end
         exp_word = pending.pop_front();
         bad = (got.out_x !== exp_word.out_x) || (got.out_y !== exp_word.out_y) ||
               (got.out_z !== exp_word.out_z) || (got.out_w !== exp_word.out_w) ||
               (got.w_zero !== exp_word.w_zero) ||
               (got.saturated !== exp_word.saturated);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp x=%h y=%h z=%h w=%h wz=%b s=%b",
                  exp_word.out_x, exp_word.out_y, exp_word.out_z, exp_word.out_w,
                  exp_word.w_zero, exp_word.saturated,
                  " got x=%h y=%h z=%h w=%h wz=%b s=%b", got.out_x, got.out_y,
                  got.out_z, got.out_w, got.w_zero, got.saturated);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]  csr_data = '0;

   vertex_transform_4x4 dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   vertex_scoreboard board = new();
   logic [CSR_W-1:0] matrix[NUM_REGS];
   int  cycles = 0;
   bit  hold_req = 1'b0;    // ask the receiver for one long stall
   bit  hold_taken = 1'b0;
   int  hold_off = 0;       // long stall cycles left, counted by the receiver

   // Coefficient of row r, column c as a signed 64-bit value
   function automatic longint coef_at(input int r, input int c);
      logic [CSR_W-1:0] reg_word;
      reg_word = matrix[r * 2 + c / 2];
      return (c % 2) ? longint'(signed'(reg_word[63:32]))
                     : longint'(signed'(reg_word[31:0]));
   endfunction

   function automatic longint clamp32(input logic signed [127:0] v, inout bit sat);
      if (v > 128'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -128'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return longint'(v);
   endfunction

   // Full-precision transform, floor shift, clamp, then optional divide
   function automatic rsp_type transform_vertex(input req_type v);
      longint                   vec[4];
      longint                   res[4];
      logic signed [127:0]      acc;
      logic signed [127:0]      quo;
      bit                       sat;
      rsp_type                  r;
      sat = 1'b0;
      vec[0] = v.in_x; vec[1] = v.in_y; vec[2] = v.in_z; vec[3] = v.in_w;
      for (int row = 0; row < 4; row++) begin
         acc = 0;
         for (int c = 0; c < 4; c++)
            acc += 128'(coef_at(row, c)) * 128'(vec[c]);
         res[row] = clamp32(acc >>> FRAC_BITS, sat);
      end
      r = '0;
      if (v.kind) begin
         if (res[3] == 0) begin
            r.w_zero = 1'b1;
         end else begin
            for (int i = 0; i < 3; i++) begin
               quo = (128'(res[i]) <<< FRAC_BITS) / 128'(res[3]);
               res[i] = clamp32(quo, sat);
            end
            res[3] = longint'(FIX_ONE);
         end
      end
      r.out_x = res[0][31:0]; r.out_y = res[1][31:0];
      r.out_z = res[2][31:0]; r.out_w = res[3][31:0];
      r.saturated = sat;
      return r;
   endfunction

   // Bias random fields toward extremes and small magnitudes
   function automatic logic [31:0] pick_component();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         3: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)) <<< 8;
         4: return 32'(0);
         default: return $urandom();
      endcase
   endfunction

   // Offer one register word and hold it until taken; caller drops valid
   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      matrix[idx] = value;
   endtask

   // Offer one vertex word and hold it until taken
   task automatic send_vertex(input req_type v);
      req_valid   <= 1'b1;
      req_payload <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_vertex(transform_vertex(v));
   endtask

   task automatic idle_sender(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Drain in-flight words, then let the pipe settle before a register write
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic load_matrix(input int style);
      logic [CSR_W-1:0] value;
      for (int i = 0; i < NUM_REGS; i++) begin
         case (style)
            0: value = coef_reset(IDX_W'(i));
            1: value = {32'h7fff_ffff, 32'h8000_0000};
            2: value = {32'h8000_0000, 32'h7fff_ffff};
            3: value = {$urandom_range(0, 1 << 18) - (1 << 17),
                        $urandom_range(0, 1 << 18) - (1 << 17)};
            default: value = {$urandom(), $urandom()};
         endcase
         write_csr(IDX_W'(i), value);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      req_type v;
      int      sent;
      sent = 0;
      while (sent < count) begin
         for (int b = $urandom_range(1, 20); b > 0 && sent < count; b--) begin
            v.kind = $urandom_range(0, 1);
            v.in_x = pick_component(); v.in_y = pick_component();
            v.in_z = pick_component();
            v.in_w = ($urandom_range(0, 7) == 0) ? 32'(0) : pick_component();
            send_vertex(v);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
      end
   endtask

   // Receiver: random stall pattern, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_payload);
         if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_off   <= 300;
            rsp_ready  <= 1'b0;
         end else if (hold_off > 0) begin
            hold_off  <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else if (cycles % 512 < 128) begin
            rsp_ready <= 1'b1;    // stretch with no stalls
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("vertex_transform_4x4_tb: done, errors");
         $finish;
      end
   end

   initial begin
      req_type v;
      for (int i = 0; i < NUM_REGS; i++) matrix[i] = coef_reset(IDX_W'(i));
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity, extremes, zero w, divide overflow
      for (int k = 0; k < 2; k++) begin
         v = '{kind: k[0], in_x: 32'h7fff_ffff, in_y: 32'h8000_0000,
               in_z: 32'h0001_0000, in_w: 32'h0002_0000};
         send_vertex(v);
         v = '{kind: k[0], in_x: 32'h0003_0000, in_y: -32'sh0001_8000,
               in_z: 32'h0, in_w: 32'h0};
         send_vertex(v);
         v = '{kind: k[0], in_x: 32'h7fff_ffff, in_y: 32'h7fff_ffff,
               in_z: 32'h8000_0000, in_w: 32'h0000_0001};
         send_vertex(v);
         v = '{kind: k[0], in_x: -32'sh0000_0001, in_y: 32'h0000_0001,
               in_z: 32'hffff_0000, in_w: -32'sh0001_0000};
         send_vertex(v);
      end
      drain();
      load_matrix(1);
      for (int k = 0; k < 6; k++) begin
         v = '{kind: k[0], in_x: (k > 1) ? 32'h7fff_ffff : 32'h8000_0000,
               in_y: 32'h8000_0000, in_z: 32'h7fff_ffff,
               in_w: (k > 3) ? 32'h0 : 32'hffff_ffff};
         send_vertex(v);
      end
      drain();
      load_matrix(2);
      random_phase(40);

      // Long hold-off: keep offering words so the pipe fills and stalls
      hold_req <= 1'b1;
      random_phase(100);
      drain();
      load_matrix(3);
      random_phase(150);
      drain();
      load_matrix(4);
      random_phase(100);
      drain();
      load_matrix(0);
      random_phase(110);

      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("vertex_transform_4x4_tb: done, clean");
      else
         $display("vertex_transform_4x4_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/vt44_pkg.sv
sv/vt44_div_lane.sv
sv/vertex_transform_4x4.sv
tb/sv/vertex_transform_4x4_tb.sv
